>>> rtl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg
// Shared constants, types and helpers of the triangle raster engine.
// ----------------------------------------------------------------------------
package trz_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int CFG_RESET_DIM  = 512;

    localparam int CRD_W   = 16;
    localparam int DEP_W   = 16;
    localparam int COL_W   = 32;
    localparam int OP_W    = 18;
    localparam int PROD_W  = 2 * OP_W;
    localparam int EDGE_W  = 38;
    localparam int DEN_W   = 36;
    localparam int NUM_W   = 52;
    localparam int QUO_W   = 16;
    localparam int CFG_W   = 10;
    localparam int IDATA_W = 176;

    localparam logic [DEP_W-1:0] DEPTH_FAR  = 16'hFFFF;
    localparam logic [DEP_W-1:0] DEPTH_NEAR = 16'h0000;

    typedef enum logic [2:0] {
        A_CLEAR = 3'd0,
        A_PUT   = 3'd1,
        A_RECT  = 3'd2,
        A_TRI   = 3'd3,
        A_ZTRI  = 3'd4,
        A_END   = 3'd5,
        A_READ  = 3'd6,
        A_NONE  = 3'd7
    } t_action;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // first and second vertex of each edge; edge three is the area edge
    function automatic logic [1:0] edge_i0(input logic [1:0] e);
        unique case (e)
            2'd0:    edge_i0 = 2'd1;
            2'd1:    edge_i0 = 2'd2;
            default: edge_i0 = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] edge_i1(input logic [1:0] e);
        unique case (e)
            2'd0:    edge_i1 = 2'd2;
            2'd1:    edge_i1 = 2'd0;
            default: edge_i1 = 2'd1;
        endcase
    endfunction

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

>>> rtl/trz_div.sv
// ----------------------------------------------------------------------------
// trz_div
// Restoring divider, one quotient bit per cycle, quotient below 2^16.
// ----------------------------------------------------------------------------
module trz_div
    import trz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_ctl         o_ctl,
    output logic [QUO_W-1:0] o_quot
);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [QUO_W-1:0] r_quot;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_done <= 1'b0;
                r_busy <= 1'b1;
                r_cnt  <= 5'(QUO_W);
                r_rem  <= i_num;
                r_den  <= NUM_W'(i_den) << (QUO_W - 1);
                r_quot <= '0;
            end else if (r_busy) begin
                if (r_rem >= r_den) begin
                    r_rem  <= r_rem - r_den;
                    r_quot <= {r_quot[QUO_W-2:0], 1'b1};
                end else begin
                    r_quot <= {r_quot[QUO_W-2:0], 1'b0};
                end
                r_den  <= r_den >> 1;
                r_cnt  <= r_cnt - 5'd1;
                r_done <= (r_cnt == 5'd1);
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_quot;

endmodule

>>> rtl/triangle_raster_with_depth_buffer_top.sv
// ----------------------------------------------------------------------------
// triangle_raster_with_depth_buffer_top
// Draw-command engine over a color framebuffer and a depth buffer.
// ----------------------------------------------------------------------------
// One command is taken at a time and yields one status item. Begin-frame,
// rectangle and triangle commands walk their clipped box one pixel per cycle
// through the single-port color and depth memories; triangles first compute
// the edge products and the area test. A covered pixel of a depth triangle
// stalls the walk for three weight products on one multiplier, sixteen steps
// of the serial divider, then a read-compare-write of the depth memory.
module triangle_raster_with_depth_buffer_top
    import trz_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // ax, ay, adepth, bx, by, bdepth, cx, cy, cdepth, color
    input  logic [IDATA_W-1:0] i_s_tdata,
    // action
    input  logic [2:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // read_color
    output logic [COL_W-1:0]   o_m_tdata,
    // status
    output logic [0:0]         o_m_tuser
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WD = XW + 1;
    localparam int HD = YW + 1;
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int RST_W = (CFG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_DIM;
    localparam int RST_H = (CFG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_DIM;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_AREA, S_ADDR, S_PUT, S_RD1, S_RD2,
        S_PIX, S_MUL, S_DIV, S_CMP, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_CLEAR, M_PUT, M_RECT, M_TRI, M_ZTRI, M_READ
    } t_mode;

    logic [COL_W-1:0] color_mem [DEPTH];
    logic [DEP_W-1:0] depth_mem [DEPTH];

    t_state                  r_state;
    t_mode                   r_mode;
    logic signed [CRD_W-1:0] r_vx [3];
    logic signed [CRD_W-1:0] r_vy [3];
    logic [DEP_W-1:0]        r_vd [3];
    logic [COL_W-1:0]        r_color;
    logic [XW-1:0]           r_minx, r_maxx, r_col;
    logic [YW-1:0]           r_maxy, r_row;
    logic [AW-1:0]           r_addr, r_rowaddr;
    logic signed [EDGE_W-1:0] r_w [4];
    logic signed [EDGE_W-1:0] r_wrow [3];
    logic                    r_neg;
    logic [2:0]              r_k;
    logic [NUM_W-1:0]        r_num;
    logic                    r_status;
    logic [COL_W-1:0]        r_rd;
    logic                    r_active;
    logic [WD-1:0]           r_fw;
    logic [HD-1:0]           r_fh;
    logic                    r_ovalid;
    logic                    r_ostatus;
    logic [COL_W-1:0]        r_odata;
    logic [COL_W-1:0]        r_cq;
    logic [DEP_W-1:0]        r_dq;

    t_div_ctl          div_ctl;
    logic [QUO_W-1:0]  div_q;
    logic              div_start;
    logic [DEN_W-1:0]  abs_area;

    // input unpacking
    t_action                 act;
    logic signed [CRD_W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic signed [OP_W-1:0]  sfw, sfh, ax18, ay18, bx18, by18, cx18, cy18;
    logic signed [OP_W-1:0]  mnx, mxx, mny, mxy, rex, rey, rsx, rsy;
    logic                    accept;

    assign act   = t_action'(i_s_tuser);
    assign in_ax = i_s_tdata[15:0];
    assign in_ay = i_s_tdata[31:16];
    assign in_bx = i_s_tdata[63:48];
    assign in_by = i_s_tdata[79:64];
    assign in_cx = i_s_tdata[111:96];
    assign in_cy = i_s_tdata[127:112];
    assign ax18  = OP_W'(in_ax);
    assign ay18  = OP_W'(in_ay);
    assign bx18  = OP_W'(in_bx);
    assign by18  = OP_W'(in_by);
    assign cx18  = OP_W'(in_cx);
    assign cy18  = OP_W'(in_cy);
    assign sfw   = $signed({{(OP_W-WD){1'b0}}, r_fw});
    assign sfh   = $signed({{(OP_W-HD){1'b0}}, r_fh});
    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        mnx = ax18;
        mxx = ax18;
        mny = ay18;
        mxy = ay18;
        if (bx18 < mnx) mnx = bx18;
        if (cx18 < mnx) mnx = cx18;
        if (bx18 > mxx) mxx = bx18;
        if (cx18 > mxx) mxx = cx18;
        if (by18 < mny) mny = by18;
        if (cy18 < mny) mny = cy18;
        if (by18 > mxy) mxy = by18;
        if (cy18 > mxy) mxy = cy18;
        rex = ax18 + bx18;
        rey = ay18 + by18;
        if (rex > sfw) rex = sfw;
        if (rey > sfh) rey = sfh;
        rsx = (ax18 < 0) ? '0 : ax18;
        rsy = (ay18 < 0) ? '0 : ay18;
    end

    // edge setup operands
    logic [1:0]              su_e, su_i0, su_i1;
    logic signed [OP_W-1:0]  su_px, su_py, su_a, su_b;
    logic signed [PROD_W-1:0] su_prod;
    logic signed [OP_W-1:0]  inc_x [3];
    logic signed [OP_W-1:0]  inc_y [3];

    always_comb begin
        su_e  = r_k[2:1];
        su_i0 = edge_i0(su_e);
        su_i1 = edge_i1(su_e);
        su_px = (su_e == 2'd3) ? OP_W'(r_vx[2]) : $signed({{(OP_W-XW){1'b0}}, r_col});
        su_py = (su_e == 2'd3) ? OP_W'(r_vy[2]) : $signed({{(OP_W-YW){1'b0}}, r_row});
        if (r_k[0]) begin
            su_a = su_py - OP_W'(r_vy[su_i0]);
            su_b = OP_W'(r_vx[su_i1]) - OP_W'(r_vx[su_i0]);
        end else begin
            su_a = su_px - OP_W'(r_vx[su_i0]);
            su_b = OP_W'(r_vy[su_i1]) - OP_W'(r_vy[su_i0]);
        end
        su_prod = su_a * su_b;
        for (int e = 0; e < 3; e++) begin
            inc_x[e] = OP_W'(r_vy[edge_i1(2'(e))]) - OP_W'(r_vy[edge_i0(2'(e))]);
            inc_y[e] = OP_W'(r_vx[edge_i1(2'(e))]) - OP_W'(r_vx[edge_i0(2'(e))]);
        end
    end

    // pixel test and weights
    logic                    covered;
    logic [DEN_W-1:0]        abs_w;
    logic signed [EDGE_W-1:0] w_sel;
    logic [NUM_W-1:0]        w_prod;
    logic                    nearer;
    logic                    last_col, last_pix;

    always_comb begin
        if (r_neg) begin
            covered = (r_w[0] <= 0) && (r_w[1] <= 0) && (r_w[2] <= 0);
        end else begin
            covered = (r_w[0] >= 0) && (r_w[1] >= 0) && (r_w[2] >= 0);
        end
        w_sel    = r_w[r_k[1:0] == 2'd3 ? 2'd0 : r_k[1:0]];
        abs_w    = DEN_W'(r_neg ? -w_sel : w_sel);
        w_prod   = NUM_W'(abs_w) * NUM_W'(r_vd[r_k[1:0] == 2'd3 ? 2'd0 : r_k[1:0]]);
        abs_area = DEN_W'(r_neg ? -r_w[3] : r_w[3]);
        nearer   = div_q < r_dq;
        last_col = r_col == r_maxx;
        last_pix = last_col && (r_row == r_maxy);
    end

    assign div_start = (r_state == S_MUL) && (r_k == 3'd3);

    trz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (abs_area),
        .o_ctl   (div_ctl),
        .o_quot  (div_q)
    );

    // memory write control
    logic             c_we, d_we;
    logic [DEP_W-1:0] d_wdata;

    always_comb begin
        c_we    = 1'b0;
        d_we    = 1'b0;
        d_wdata = DEPTH_FAR;
        unique case (r_state)
            S_PUT: begin
                c_we    = 1'b1;
                d_we    = 1'b1;
                d_wdata = DEPTH_NEAR;
            end
            S_PIX: begin
                c_we = (r_mode == M_CLEAR) || (r_mode == M_RECT) ||
                       ((r_mode == M_TRI) && covered);
                d_we = (r_mode == M_CLEAR);
            end
            S_CMP: begin
                c_we    = nearer;
                d_we    = nearer;
                d_wdata = div_q;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            color_mem[r_addr] <= r_color;
        end
        r_cq <= color_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            depth_mem[r_addr] <= d_wdata;
        end
        r_dq <= depth_mem[r_addr];
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ostatus;

    logic [AW-1:0] row_addr;
    assign row_addr = AW'(r_row) * AW'(r_fw) + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_fw     <= WD'(RST_W);
            r_fh     <= HD'(RST_H);
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            if (o_m_tvalid && i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_WIDTH) begin
                    if (i_cfg_data == '0) r_fw <= WD'(1);
                    else if (int'(i_cfg_data) > MAX_WIDTH) r_fw <= WD'(MAX_WIDTH);
                    else r_fw <= WD'(i_cfg_data);
                end else begin
                    if (i_cfg_data == '0) r_fh <= HD'(1);
                    else if (int'(i_cfg_data) > MAX_HEIGHT) r_fh <= HD'(MAX_HEIGHT);
                    else r_fh <= HD'(i_cfg_data);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_vx[0]  <= in_ax;
                        r_vy[0]  <= in_ay;
                        r_vd[0]  <= i_s_tdata[47:32];
                        r_vx[1]  <= in_bx;
                        r_vy[1]  <= in_by;
                        r_vd[1]  <= i_s_tdata[95:80];
                        r_vx[2]  <= in_cx;
                        r_vy[2]  <= in_cy;
                        r_vd[2]  <= i_s_tdata[143:128];
                        r_color  <= i_s_tdata[175:144];
                        r_rd     <= '0;
                        r_k      <= '0;
                        unique case (act)
                            A_CLEAR: begin
                                if (r_active) begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= 1'b0;
                                    r_active <= 1'b1;
                                    r_mode   <= M_CLEAR;
                                    r_minx   <= '0;
                                    r_col    <= '0;
                                    r_row    <= '0;
                                    r_maxx   <= XW'(r_fw - WD'(1));
                                    r_maxy   <= YW'(r_fh - HD'(1));
                                    r_state  <= S_ADDR;
                                end
                            end
                            A_PUT, A_READ: begin
                                if ((act == A_PUT && !r_active) || ax18 < 0 || ay18 < 0 ||
                                    ax18 >= sfw || ay18 >= sfh) begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= 1'b0;
                                    r_mode   <= (act == A_PUT) ? M_PUT : M_READ;
                                    r_col    <= XW'(ax18);
                                    r_row    <= YW'(ay18);
                                    r_state  <= S_ADDR;
                                end
                            end
                            A_RECT: begin
                                if (!r_active || bx18 < 0 || by18 < 0) begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end else if (rsx < rex && rsy < rey) begin
                                    r_status <= 1'b0;
                                    r_mode   <= M_RECT;
                                    r_minx   <= XW'(rsx);
                                    r_col    <= XW'(rsx);
                                    r_row    <= YW'(rsy);
                                    r_maxx   <= XW'(rex - 1);
                                    r_maxy   <= YW'(rey - 1);
                                    r_state  <= S_ADDR;
                                end else begin
                                    r_status <= 1'b0;
                                    r_state  <= S_DONE;
                                end
                            end
                            A_TRI, A_ZTRI: begin
                                if (!r_active) begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end else if (!(mxx < 0 || mxy < 0 || mnx >= sfw ||
                                               mny >= sfh)) begin
                                    r_status <= 1'b0;
                                    r_mode   <= (act == A_ZTRI) ? M_ZTRI : M_TRI;
                                    r_minx   <= (mnx < 0) ? '0 : XW'(mnx);
                                    r_col    <= (mnx < 0) ? '0 : XW'(mnx);
                                    r_row    <= (mny < 0) ? '0 : YW'(mny);
                                    r_maxx   <= (mxx >= sfw) ? XW'(r_fw - WD'(1)) : XW'(mxx);
                                    r_maxy   <= (mxy >= sfh) ? YW'(r_fh - HD'(1)) : YW'(mxy);
                                    r_state  <= S_SETUP;
                                end else begin
                                    r_status <= 1'b0;
                                    r_state  <= S_DONE;
                                end
                            end
                            A_END: begin
                                if (!r_active) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_status <= 1'b0;
                                    r_active <= 1'b0;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_status <= 1'b1;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    if (r_k[0]) r_w[su_e] <= r_w[su_e] - EDGE_W'(su_prod);
                    else r_w[su_e] <= EDGE_W'(su_prod);
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) r_state <= S_AREA;
                end
                S_AREA: begin
                    if (r_w[3] == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_neg   <= r_w[3] < 0;
                        r_wrow  <= r_w[0:2];
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr    <= row_addr;
                    r_rowaddr <= row_addr;
                    unique case (r_mode)
                        M_PUT:   r_state <= S_PUT;
                        M_READ:  r_state <= S_RD1;
                        default: r_state <= S_PIX;
                    endcase
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_rd    <= r_cq;
                    r_state <= S_DONE;
                end
                S_MUL: begin
                    if (r_k == 3'd3) begin
                        r_state <= S_DIV;
                    end else begin
                        r_num <= r_num + w_prod;
                        r_k   <= r_k + 3'd1;
                    end
                end
                S_DIV: begin
                    if (div_ctl.done) r_state <= S_CMP;
                end
                S_PIX, S_CMP: begin
                    if (r_state == S_PIX && r_mode == M_ZTRI && covered) begin
                        r_k     <= '0;
                        r_num   <= '0;
                        r_state <= S_MUL;
                    end else if (last_pix) begin
                        r_state <= S_DONE;
                    end else if (last_col) begin
                        r_state   <= S_PIX;
                        r_row     <= r_row + YW'(1);
                        r_col     <= r_minx;
                        r_rowaddr <= r_rowaddr + AW'(r_fw);
                        r_addr    <= r_rowaddr + AW'(r_fw);
                        for (int e = 0; e < 3; e++) begin
                            r_wrow[e] <= r_wrow[e] - EDGE_W'(inc_y[e]);
                            r_w[e]    <= r_wrow[e] - EDGE_W'(inc_y[e]);
                        end
                    end else begin
                        r_state <= S_PIX;
                        r_col   <= r_col + XW'(1);
                        r_addr  <= r_addr + AW'(1);
                        for (int e = 0; e < 3; e++) begin
                            r_w[e] <= r_w[e] + EDGE_W'(inc_x[e]);
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_odata   <= r_rd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX) |-> (r_col <= r_maxx && r_row <= r_maxy))
        else $error("pixel walk left its box");

    a_walk_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX) |-> (r_addr == row_addr))
        else $error("walk address out of step with position");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_ctl.start)
        else $error("divider started while busy");

endmodule
